### design/keypad_code_entry_lock_assert.svh
// Assertion macros shared by the keypad lock checker.
`ifndef KEYPAD_CODE_ENTRY_LOCK_ASSERT_SVH
`define KEYPAD_CODE_ENTRY_LOCK_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define KCEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is low.
`define KCEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define KCEL_ASSERT_RESET(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/kcel_pkg.sv
// Types, codes and helpers shared by the keypad lock modules.
`default_nettype none

package kcel_pkg;

  localparam int CodeLength = 4;
  localparam int CntW       = $clog2(CodeLength + 1);
  localparam int IdxW       = (CodeLength > 1) ? $clog2(CodeLength) : 1;

  localparam logic [1:0] StIgnored  = 2'd0;
  localparam logic [1:0] StAccepted = 2'd1;
  localparam logic [1:0] StUnlock   = 2'd2;
  localparam logic [1:0] StBad      = 2'd3;

  localparam logic [1:0] CfgDoorCode   = 2'd0;
  localparam logic [1:0] CfgDebounceMs = 2'd1;
  localparam logic [1:0] CfgKeypadId   = 2'd2;

  localparam logic [7:0] KeyStar  = 8'h2A;
  localparam logic [7:0] KeyDel   = 8'h44;
  localparam logic [7:0] KeyClear = 8'h43;
  localparam logic [7:0] KeyHash  = 8'h23;
  localparam logic [7:0] KeyZero  = 8'h30;
  localparam logic [7:0] KeyNine  = 8'h39;

  localparam logic [31:0] DoorCodeRst   = 32'd1094861636;
  localparam logic [15:0] DebounceMsRst = 16'd30;
  localparam logic [7:0]  KeypadIdRst   = 8'd0;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  key_char;
  } kcel_item_t;

  typedef struct packed {
    logic [7:0]      source_id;
    logic [31:0]     event_time;
    logic [CntW-1:0] entered_count;
    logic [1:0]      status;
  } kcel_res_t;

  localparam int InW  = $bits(kcel_item_t);
  localparam int ResW = $bits(kcel_res_t);
  localparam int OutW = ((ResW + 7) / 8) * 8;

  function automatic logic [7:0] code_char(input logic [31:0] code, input int unsigned pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos < 4) begin
      ch = code[(31 - 8 * pos) -: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/kcel_in_reg.sv
// Input register stage for key press transactions.
`default_nettype none

module kcel_in_reg
  import kcel_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire kcel_item_t in_item,
  input  wire logic       take,
  output logic            s_valid,
  output kcel_item_t      s_item
);

  logic       valid_r;
  logic       valid_nxt;
  kcel_item_t item_r;
  logic       load;

  assign in_ready  = rst_n && (!valid_r || take);
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

`default_nettype wire

### design/kcel_entry.sv
// Code entry state, debounce check, settings and result computation.
`default_nettype none

module kcel_entry
  import kcel_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        fire,
  input  wire kcel_item_t  item,
  output kcel_res_t        res
);

  logic [31:0]     door_code_r;
  logic [15:0]     debounce_ms_r;
  logic [7:0]      keypad_id_r;
  logic [7:0]      digit_store_r [CodeLength];
  logic [CntW-1:0] digit_count_r;
  logic [CntW-1:0] digit_count_nxt;
  logic [31:0]     last_press_r;
  logic [31:0]     last_press_nxt;
  logic [31:0]     delta;
  logic            ignored;
  logic            match;
  logic            wr_digit;
  logic [1:0]      status;
  logic            is_event;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_code_r   <= DoorCodeRst;
      debounce_ms_r <= DebounceMsRst;
      keypad_id_r   <= KeypadIdRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgDoorCode:   door_code_r   <= cfg_wdata;
        CfgDebounceMs: debounce_ms_r <= cfg_wdata[15:0];
        CfgKeypadId:   keypad_id_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    match = (digit_count_r == CntW'(CodeLength));
    for (int i = 0; i < CodeLength; i++) begin
      if (digit_store_r[i] != code_char(door_code_r, i)) begin
        match = 1'b0;
      end
    end
  end

  assign delta   = item.now_ms - last_press_r;
  assign ignored = delta < {16'd0, debounce_ms_r};

  always_comb begin
    digit_count_nxt = digit_count_r;
    last_press_nxt  = last_press_r;
    status          = StAccepted;
    wr_digit        = 1'b0;
    if (ignored) begin
      status = StIgnored;
    end else begin
      last_press_nxt = item.now_ms;
      case (item.key_char) inside
        KeyStar, KeyDel: begin
          if (digit_count_r != '0) begin
            digit_count_nxt = digit_count_r - CntW'(1);
          end
        end
        KeyClear: begin
          digit_count_nxt = '0;
        end
        [KeyZero:KeyNine]: begin
          if (digit_count_r < CntW'(CodeLength)) begin
            wr_digit        = 1'b1;
            digit_count_nxt = digit_count_r + CntW'(1);
          end
        end
        KeyHash: begin
          status          = match ? StUnlock : StBad;
          digit_count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
      last_press_r  <= '0;
    end else if (fire) begin
      digit_count_r <= digit_count_nxt;
      last_press_r  <= last_press_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_digit) begin
      digit_store_r[digit_count_r[IdxW-1:0]] <= item.key_char;
    end
  end

  assign is_event = (status == StUnlock) || (status == StBad);

  always_comb begin
    res.status        = status;
    res.entered_count = digit_count_nxt;
    res.event_time    = is_event ? item.now_ms : 32'd0;
    res.source_id     = is_event ? keypad_id_r : 8'd0;
  end

endmodule

`default_nettype wire

### design/kcel_out_reg.sv
// Result register stage for every press result.
`default_nettype none

module kcel_out_reg
  import kcel_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      s_valid,
  input  wire kcel_res_t s_res,
  output logic           can_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output kcel_res_t      out_res
);

  logic      valid_r;
  logic      valid_nxt;
  kcel_res_t res_r;
  logic      load;

  assign can_take  = !valid_r || out_ready;
  assign load      = s_valid && can_take;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= s_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### design/keypad_code_entry_lock.sv
// Top level of the keypad code entry lock.
//
//   channel | direction | payload
//   in_     | slave     | key press: key_char, now_ms
//   out_    | master    | result: status, entered_count, event_time, source_id
//   cfg_    | write     | door_code, debounce_ms, keypad_id
//
// One press per cycle sustained when the output is not stalled; a press passes
// the input register and then the result register before it shows up as a result.
// The per-press update of digit count, digit store and last press time is
// combinational logic between the input register and the result register.
// Synchronous active-low reset clears the entry, the last press time, both
// stage valids and loads the register defaults; the digit store is not reset.
// A stalled output holds the result and backs up into the input register.
`default_nettype none

module keypad_code_entry_lock
  import kcel_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [InW-1:0]  in_tdata,   // key_char[7:0], now_ms[39:8]
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OutW-1:0]      out_tdata,  // status[1:0], entered_count[4:2],
                                           // event_time[36:5], source_id[44:37]
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_wdata
);

  kcel_item_t s_item;
  kcel_res_t  calc_res;
  kcel_res_t  out_res;
  logic       s_valid;
  logic       can_take;
  logic       fire;

  assign fire = s_valid && can_take;

  kcel_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (kcel_item_t'(in_tdata)),
    .take     (fire),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  kcel_entry u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s_item),
    .res       (calc_res)
  );

  kcel_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (s_valid),
    .s_res     (calc_res),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {(OutW - ResW)'(0), out_res};

endmodule

`default_nettype wire

### design/kcel_checker.sv
// Port-level checker for the keypad lock, bound to the top level.
`default_nettype none

`include "keypad_code_entry_lock_assert.svh"

module kcel_checker
  import kcel_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_tvalid,
  input wire logic            in_tready,
  input wire logic            out_tvalid,
  input wire logic            out_tready,
  input wire logic [OutW-1:0] out_tdata
);

  kcel_res_t res;
  logic      in_xact;
  logic      is_event;

  assign res      = kcel_res_t'(out_tdata[ResW-1:0]);
  assign in_xact  = in_tvalid && in_tready;
  assign is_event = (res.status == StUnlock) || (res.status == StBad);

  `KCEL_ASSERT_RESET(a_reset_drops_out, clk, !rst_n, !out_tvalid, "result valid after reset")
  `KCEL_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed")
  `KCEL_ASSERT_NOW(a_result_has_press, clk, rst_n, $rose(out_tvalid),
                   $past(in_xact, 2), "result without a press two cycles before")
  `KCEL_ASSERT_NOW(a_submit_clears, clk, rst_n, out_tvalid && is_event,
                   res.entered_count == '0, "entry not cleared on submit")

endmodule

bind keypad_code_entry_lock kcel_checker u_kcel_checker (.*);

`default_nettype wire
